>>> design/dpbd_pkg.sv
package dpbd_pkg;

    localparam int SAMPLE_W = 12;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OFF_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAT_THR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_CNT = 2'd3;

    localparam logic [SAMPLE_W-1:0] OFF_THR_RST  = 12'd1228;
    localparam logic [SAMPLE_W-1:0] ON_THR_RST   = 12'd1638;
    localparam logic [SAMPLE_W-1:0] BAT_THR_RST  = 12'd1092;
    localparam logic [COUNT_W-1:0]  HOLD_CNT_RST = 16'd50000;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] off_thr;
        logic [SAMPLE_W-1:0] on_thr;
        logic [SAMPLE_W-1:0] bat_thr;
        logic [COUNT_W-1:0]  hold_cnt;
    } t_cfg;

    typedef struct packed {
        logic plugged;
        logic unplugged;
        logic battery;
        logic halted;
    } t_flags;

endpackage

>>> design/dpbd_detect.sv
module dpbd_detect (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [dpbd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_in_test,
    input  logic                          i_charge_open,
    input  logic                          i_rearm,
    input  dpbd_pkg::t_cfg                i_cfg,
    output dpbd_pkg::t_flags              o_flags,
    output dpbd_pkg::t_flags              o_flags_next
);

    dpbd_pkg::t_flags r_flags, n_flags;
    logic r_first_boot, n_first_boot;
    logic r_prev_low, n_prev_low;
    logic r_prev_high, n_prev_high;
    logic [dpbd_pkg::COUNT_W-1:0] r_count, n_count;

    logic                         low, high;
    logic [dpbd_pkg::COUNT_W-1:0] cnt_low, cnt_high;

    always_comb begin
        n_flags      = r_flags;
        n_first_boot = r_first_boot;
        n_prev_low   = r_prev_low;
        n_prev_high  = r_prev_high;
        n_count      = r_count;
        low          = 1'b0;
        high         = 1'b0;
        cnt_low      = r_count;
        cnt_high     = r_count;

        if (i_rearm) begin
            n_first_boot      = 1'b0;
            n_flags.plugged   = 1'b0;
            n_flags.unplugged = 1'b0;
            n_flags.halted    = 1'b0;
        end else if (!r_flags.halted) begin
            if (i_in_test) begin
                if (i_sample > i_cfg.bat_thr && i_charge_open) begin
                    if (r_count > i_cfg.hold_cnt) begin
                        n_count         = '0;
                        n_flags.battery = 1'b1;
                        n_flags.halted  = 1'b1;
                    end else if (r_count != dpbd_pkg::COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end else if (r_first_boot && i_sample > i_cfg.on_thr) begin
                n_flags.plugged = 1'b1;
                n_flags.halted  = 1'b1;
            end else begin
                // low run first, then high run on the same sample
                low = !r_flags.unplugged && (i_sample < i_cfg.off_thr);
                if (low) begin
                    if (!r_prev_low) begin
                        cnt_low = '0;
                    end else if (r_count != dpbd_pkg::COUNT_MAX) begin
                        cnt_low = r_count + 1'b1;
                    end
                    if (cnt_low > i_cfg.hold_cnt) begin
                        n_flags.unplugged = 1'b1;
                        cnt_low           = '0;
                    end
                end
                n_prev_low = low;

                cnt_high = cnt_low;
                high = n_flags.unplugged && (i_sample > i_cfg.on_thr);
                if (high) begin
                    if (!r_prev_high) begin
                        cnt_high = '0;
                    end else if (cnt_low != dpbd_pkg::COUNT_MAX) begin
                        cnt_high = cnt_low + 1'b1;
                    end
                    if (cnt_high > i_cfg.hold_cnt) begin
                        n_flags.plugged = 1'b1;
                        n_flags.halted  = 1'b1;
                        cnt_high        = '0;
                    end
                end
                n_prev_high = high;
                n_count     = cnt_high;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags      <= '0;
            r_first_boot <= 1'b1;
            r_prev_low   <= 1'b0;
            r_prev_high  <= 1'b0;
            r_count      <= '0;
        end else if (i_accept) begin
            r_flags      <= n_flags;
            r_first_boot <= n_first_boot;
            r_prev_low   <= n_prev_low;
            r_prev_high  <= n_prev_high;
            r_count      <= n_count;
        end
    end

    assign o_flags      = r_flags;
    assign o_flags_next = n_flags;

endmodule

>>> design/debounced_plug_and_battery_detector_top.sv
// channel | valid        | stall        | payload
// in      | i_in_valid   | o_in_stall   | i_sample, i_in_test, i_charge_open, i_rearm
// out     | o_out_valid  | i_out_stall  | o_plugged_in, o_unplug_seen, o_battery_ok,
//         |              |              | o_sampling_stopped
// cfg     | i_cfg_we     | -            | i_cfg_idx, i_cfg_data
//
// One beat per cycle while the input is not stalled; a result is registered and appears in the cycle after
// its input beat is accepted. All detection logic sits between the state registers and the result register.
// Synchronous active-low reset restores register defaults and resets detector state and output valid.
// Input is stalled only while a result is held and the output is stalled.
module debounced_plug_and_battery_detector_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dpbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dpbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [dpbd_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                            i_in_test,
    input  logic                            i_charge_open,
    input  logic                            i_rearm,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_plugged_in,
    output logic                            o_unplug_seen,
    output logic                            o_battery_ok,
    output logic                            o_sampling_stopped
);

    dpbd_pkg::t_cfg   r_cfg;
    dpbd_pkg::t_flags state_flags, next_flags;
    dpbd_pkg::t_flags r_out;
    logic             r_out_valid;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.off_thr  <= dpbd_pkg::OFF_THR_RST;
            r_cfg.on_thr   <= dpbd_pkg::ON_THR_RST;
            r_cfg.bat_thr  <= dpbd_pkg::BAT_THR_RST;
            r_cfg.hold_cnt <= dpbd_pkg::HOLD_CNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dpbd_pkg::CFG_OFF_THR:  r_cfg.off_thr  <= i_cfg_data[dpbd_pkg::SAMPLE_W-1:0];
                dpbd_pkg::CFG_ON_THR:   r_cfg.on_thr   <= i_cfg_data[dpbd_pkg::SAMPLE_W-1:0];
                dpbd_pkg::CFG_BAT_THR:  r_cfg.bat_thr  <= i_cfg_data[dpbd_pkg::SAMPLE_W-1:0];
                dpbd_pkg::CFG_HOLD_CNT: r_cfg.hold_cnt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    dpbd_detect u_detect (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_sample      (i_sample),
        .i_in_test     (i_in_test),
        .i_charge_open (i_charge_open),
        .i_rearm       (i_rearm),
        .i_cfg         (r_cfg),
        .o_flags       (state_flags),
        .o_flags_next  (next_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= next_flags;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_plugged_in       = r_out.plugged;
    assign o_unplug_seen      = r_out.unplugged;
    assign o_battery_ok       = r_out.battery;
    assign o_sampling_stopped = r_out.halted;

`ifndef ASSERT_OFF
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out == state_flags)
        else $error("held result differs from detector state");

    a_plug_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        state_flags.plugged |-> state_flags.halted)
        else $error("plug-in confirmed without halting");

    a_rearm_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_rearm |=> !o_plugged_in && !o_unplug_seen && !o_sampling_stopped)
        else $error("rearm beat did not clear flags");
`endif

endmodule

>>> sim/debounced_plug_and_battery_detector_top_tb.sv
`timescale 1ns / 100ps

module debounced_plug_and_battery_detector_top_tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int SAT_BEATS   = 8;

    typedef logic [dpbd_pkg::SAMPLE_W-1:0] t_sample;
    typedef logic [dpbd_pkg::COUNT_W-1:0]  t_count;
    typedef logic [dpbd_pkg::CFG_DATA_W-dpbd_pkg::SAMPLE_W-1:0] t_pad;

    typedef struct packed {
        logic [dpbd_pkg::SAMPLE_W-1:0] sample;
        logic                          in_test;
        logic                          charge_open;
        logic                          rearm;
    } t_det_beat;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [dpbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [dpbd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic [dpbd_pkg::SAMPLE_W-1:0]   i_sample = '0;
    logic                            i_in_test = 1'b0;
    logic                            i_charge_open = 1'b0;
    logic                            i_rearm = 1'b0;
    logic                            i_out_stall = 1'b0;
    logic                            o_in_stall;
    logic                            o_out_valid;
    logic                            o_plugged_in;
    logic                            o_unplug_seen;
    logic                            o_battery_ok;
    logic                            o_sampling_stopped;

    debounced_plug_and_battery_detector_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_sample           (i_sample),
        .i_in_test          (i_in_test),
        .i_charge_open      (i_charge_open),
        .i_rearm            (i_rearm),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_plugged_in       (o_plugged_in),
        .o_unplug_seen      (o_unplug_seen),
        .o_battery_ok       (o_battery_ok),
        .o_sampling_stopped (o_sampling_stopped)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_det_beat         sample_q[$];
    dpbd_pkg::t_flags  flags_q[$];
    t_det_beat         cur_beat;
    int                beats_queued = 0;
    int                send_idle_pct = 35;
    int                recv_idle_pct = 61;
    int                err_cnt = 0;
    int                quiet_cycles = 0;

    // detector shadow state
    dpbd_pkg::t_cfg det_cfg = '{dpbd_pkg::OFF_THR_RST, dpbd_pkg::ON_THR_RST,
                                dpbd_pkg::BAT_THR_RST, dpbd_pkg::HOLD_CNT_RST};
    logic           st_first_boot = 1'b1;
    logic           st_unplugged = 1'b0;
    logic           st_plugged = 1'b0;
    logic           st_prev_low = 1'b0;
    logic           st_prev_high = 1'b0;
    t_count         st_run = '0;
    logic           st_battery = 1'b0;
    logic           st_halted = 1'b0;

    function automatic t_count next_run(input logic prev);
        if (!prev) begin
            return '0;
        end else if (st_run != dpbd_pkg::COUNT_MAX) begin
            return st_run + 1'b1;
        end
        return st_run;
    endfunction

    task automatic predict_beat(input t_det_beat b);
        logic low;
        logic high;
        if (b.rearm) begin
            st_first_boot = 1'b0;
            st_plugged    = 1'b0;
            st_unplugged  = 1'b0;
            st_halted     = 1'b0;
        end else if (!st_halted) begin
            if (b.in_test) begin
                if (b.sample > det_cfg.bat_thr && b.charge_open) begin
                    if (st_run > det_cfg.hold_cnt) begin
                        st_run     = '0;
                        st_battery = 1'b1;
                        st_halted  = 1'b1;
                    end else if (st_run != dpbd_pkg::COUNT_MAX) begin
                        st_run = st_run + 1'b1;
                    end
                end
            end else if (st_first_boot && b.sample > det_cfg.on_thr) begin
                st_plugged = 1'b1;
                st_halted  = 1'b1;
            end else begin
                low = !st_unplugged && (b.sample < det_cfg.off_thr);
                if (low) begin
                    st_run = next_run(st_prev_low);
                    if (st_run > det_cfg.hold_cnt) begin
                        st_unplugged = 1'b1;
                        st_run       = '0;
                    end
                end
                st_prev_low = low;
                high = st_unplugged && (b.sample > det_cfg.on_thr);
                if (high) begin
                    st_run = next_run(st_prev_high);
                    if (st_run > det_cfg.hold_cnt) begin
                        st_plugged = 1'b1;
                        st_run     = '0;
                        st_halted  = 1'b1;
                    end
                end
                st_prev_high = high;
            end
        end
        flags_q.push_back(dpbd_pkg::t_flags'{st_plugged, st_unplugged, st_battery, st_halted});
    endtask

    function automatic void compare_flag(input string name, input logic exp_v, input logic act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0b, got %0b", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_beat(cur_beat);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_beat = sample_q.pop_front();
                    i_in_valid    <= 1'b1;
                    i_sample      <= cur_beat.sample;
                    i_in_test     <= cur_beat.in_test;
                    i_charge_open <= cur_beat.charge_open;
                    i_rearm       <= cur_beat.rearm;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        dpbd_pkg::t_flags exp_f;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (flags_q.size() == 0) begin
                    $error("result beat with no expectation pending");
                    err_cnt++;
                end else begin
                    exp_f = flags_q.pop_front();
                    compare_flag("plugged_in", exp_f.plugged, o_plugged_in);
                    compare_flag("unplug_seen", exp_f.unplugged, o_unplug_seen);
                    compare_flag("battery_ok", exp_f.battery, o_battery_ok);
                    compare_flag("sampling_stopped", exp_f.halted, o_sampling_stopped);
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("debounced_plug_and_battery_detector_top_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_beat(input t_sample s, input logic test,
                             input logic open, input logic rearm);
        sample_q.push_back(t_det_beat'{s, test, open, rearm});
        beats_queued++;
    endtask

    task automatic write_reg(input logic [dpbd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dpbd_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            dpbd_pkg::CFG_OFF_THR:  det_cfg.off_thr  = data[dpbd_pkg::SAMPLE_W-1:0];
            dpbd_pkg::CFG_ON_THR:   det_cfg.on_thr   = data[dpbd_pkg::SAMPLE_W-1:0];
            dpbd_pkg::CFG_BAT_THR:  det_cfg.bat_thr  = data[dpbd_pkg::SAMPLE_W-1:0];
            dpbd_pkg::CFG_HOLD_CNT: det_cfg.hold_cnt = data[dpbd_pkg::COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // upper data bits above a threshold's width are junk and must be dropped
    task automatic set_config(input t_sample off_t, input t_sample on_t,
                              input t_sample bat_t, input t_count hold);
        t_pad pad;
        pad = t_pad'($urandom);
        write_reg(dpbd_pkg::CFG_OFF_THR, {pad, off_t});
        pad = t_pad'($urandom);
        write_reg(dpbd_pkg::CFG_ON_THR, {pad, on_t});
        pad = t_pad'($urandom);
        write_reg(dpbd_pkg::CFG_BAT_THR, {pad, bat_t});
        write_reg(dpbd_pkg::CFG_HOLD_CNT, hold);
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || i_in_valid || flags_q.size() != 0 || o_out_valid) begin
            @(posedge i_clk);
            #1;
        end
        repeat (3) @(posedge i_clk);
    endtask

    function automatic t_sample below(input t_sample thr);
        return (thr == 0) ? '0 : t_sample'($urandom_range(thr - 1, 0));
    endfunction

    function automatic t_sample above(input t_sample thr);
        return (thr == '1) ? '1 : t_sample'($urandom_range(4095, thr + 1));
    endfunction

    // occasionally breaks a run with an arbitrary reading
    function automatic t_sample jitter(input t_sample s);
        return ($urandom_range(9) == 0) ? t_sample'($urandom_range(4095)) : s;
    endfunction

    function automatic int run_length();
        if (det_cfg.hold_cnt < 16) begin
            return int'(det_cfg.hold_cnt) + int'($urandom_range(3));
        end
        return int'($urandom_range(24, 1));
    endfunction

    task automatic fill_random(input int n);
        int stop_at;
        int kind;
        int len;
        int k;
        stop_at = beats_queued + n;
        while (beats_queued < stop_at) begin
            kind = int'($urandom_range(99));
            if (kind < 30) begin
                len = run_length();
                for (k = 0; k < len; k++) begin
                    push_beat(jitter(below(det_cfg.off_thr)), 1'b0,
                              1'($urandom_range(1)), 1'b0);
                end
                len = run_length();
                for (k = 0; k < len; k++) begin
                    push_beat(jitter(above(det_cfg.on_thr)), 1'b0,
                              1'($urandom_range(1)), 1'b0);
                end
                if ($urandom_range(3) != 0) begin
                    push_beat(t_sample'($urandom_range(4095)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'b1);
                end
            end else if (kind < 50) begin
                len = run_length();
                for (k = 0; k < len; k++) begin
                    push_beat(jitter(above(det_cfg.bat_thr)), 1'b1,
                              $urandom_range(9) != 0, 1'b0);
                end
                if ($urandom_range(3) != 0) begin
                    push_beat(t_sample'($urandom_range(4095)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'b1);
                end
            end else if (kind < 60) begin
                push_beat(t_sample'($urandom_range(4095)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'b1);
            end else begin
                push_beat(t_sample'($urandom_range(4095)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), $urandom_range(7) == 0);
            end
        end
    endtask

    initial begin
        int p;
        int k;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: first boot, halt, rearm, short runs
        push_beat(12'd0,    1'b0, 1'b0, 1'b0);
        push_beat(12'd1638, 1'b0, 1'b0, 1'b0);
        push_beat(12'd1228, 1'b0, 1'b1, 1'b0);
        push_beat(12'd1639, 1'b0, 1'b0, 1'b0);
        push_beat(12'd4095, 1'b1, 1'b1, 1'b0);
        push_beat(12'd2000, 1'b0, 1'b0, 1'b1);
        push_beat(12'd4095, 1'b0, 1'b0, 1'b0);
        push_beat(12'd1227, 1'b0, 1'b0, 1'b0);
        push_beat(12'd0,    1'b1, 1'b0, 1'b0);
        push_beat(12'd1093, 1'b1, 1'b1, 1'b0);
        push_beat(12'd1092, 1'b1, 1'b1, 1'b0);
        wait_drained();

        // full unplug / plug sequence, then battery
        set_config(12'd2048, 12'd2048, 12'd2048, 16'd1);
        for (k = 0; k < 3; k++) push_beat(12'd0, 1'b0, 1'b0, 1'b0);
        for (k = 0; k < 3; k++) push_beat(12'd4095, 1'b0, 1'b0, 1'b0);
        push_beat(12'd100, 1'b0, 1'b0, 1'b1);
        for (k = 0; k < 3; k++) push_beat(12'd4095, 1'b1, 1'b1, 1'b0);
        push_beat(12'd4095, 1'b1, 1'b1, 1'b1);
        wait_drained();

        // inverted thresholds: first boot plugs in at once, then a rearm and one low sample
        set_config(12'd4095, 12'd0, 12'd4095, 16'd0);
        for (k = 0; k < 3; k++) push_beat(12'd1, 1'b0, 1'b0, 1'b0);
        push_beat(12'd0, 1'b0, 1'b0, 1'b1);
        push_beat(12'd4095, 1'b1, 1'b1, 1'b0);
        push_beat(12'd0, 1'b0, 1'b0, 1'b0);
        wait_drained();

        for (p = 0; p < 16; p++) begin
            if (p == 6) begin
                set_idle(61, 35);
            end else if (p == 12) begin
                set_idle(0, 0);
            end
            case (p)
                3:  set_config(12'd0, 12'd4095, 12'd4095, 16'd0);
                8:  set_config(12'd4095, 12'd0, 12'd0, 16'd65534);
                12: set_config(t_sample'($urandom_range(4095)), t_sample'($urandom_range(4095)),
                               t_sample'($urandom_range(4095)), t_count'($urandom));
                default: set_config(t_sample'($urandom_range(4095)),
                                    t_sample'($urandom_range(4095)),
                                    t_sample'($urandom_range(4095)),
                                    t_count'($urandom_range(6)));
            endcase
            fill_random(50);
            wait_drained();
        end

        // a hold of all ones never confirms, then a lower hold confirms at once
        set_config(12'd2048, 12'd2048, 12'd0, 16'hFFFF);
        push_beat(12'd0, 1'b0, 1'b0, 1'b1);
        for (k = 0; k < SAT_BEATS; k++) push_beat(12'd4095, 1'b1, 1'b1, 1'b0);
        wait_drained();
        set_config(12'd2048, 12'd2048, 12'd0, 16'd3);
        push_beat(12'd4095, 1'b1, 1'b1, 1'b0);
        push_beat(12'd4095, 1'b1, 1'b1, 1'b0);
        push_beat(12'd0, 1'b0, 1'b0, 1'b1);
        push_beat(12'd4095, 1'b1, 1'b1, 1'b0);
        wait_drained();

        if (err_cnt == 0 && flags_q.size() == 0) begin
            $display("debounced_plug_and_battery_detector_top_tb: done, clean");
        end else begin
            $display("debounced_plug_and_battery_detector_top_tb: done, errors");
        end
        $finish;
    end

endmodule
